>>> rtl/core/tcp_nat_translation_table_core_macros.svh
// ---------------------------------------------------------------------------
// tcp nat translation table assertion macros
// shared property forms for the table core assertions
// ---------------------------------------------------------------------------
`ifndef TCP_NAT_TRANSLATION_TABLE_CORE_MACROS_SVH
`define TCP_NAT_TRANSLATION_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define TNT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TNT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tnt_pkg.sv
// ---------------------------------------------------------------------------
// tnt_pkg
// types, constants and codes shared by the translation table core
// ---------------------------------------------------------------------------
package tnt_pkg;

	localparam int TBL_ENTRIES = 64;
	localparam int TBL_IW      = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;
	localparam int PORT_FIRST  = 12345;
	localparam int PORT_LAST   = 23456;
	localparam int POOL_COUNT  = PORT_LAST - PORT_FIRST + 1;
	localparam int POOL_WORDS  = (POOL_COUNT + 31) / 32;
	localparam int POOL_AW     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
	localparam int POOL_OFF_W  = POOL_AW + 5;
	localparam int POOL_LAST_BITS = POOL_COUNT - 32 * (POOL_WORDS - 1);
	localparam logic [31:0] POOL_LAST_MASK = 32'((64'd1 << POOL_LAST_BITS) - 64'd1);

	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_ACK = 4;

	localparam logic [1:0] DIR_OUT = 2'd0;
	localparam logic [1:0] DIR_IN  = 2'd1;

	localparam logic [1:0] ACT_FWD  = 2'd0;
	localparam logic [1:0] ACT_ICMP = 2'd1;
	localparam logic [1:0] ACT_DROP = 2'd2;

	localparam logic [2:0] CFG_EXT_IP    = 3'd0;
	localparam logic [2:0] CFG_RULE_EN   = 3'd1;
	localparam logic [2:0] CFG_RULE_XIP  = 3'd2;
	localparam logic [2:0] CFG_RULE_XPRT = 3'd3;
	localparam logic [2:0] CFG_RULE_IIP  = 3'd4;
	localparam logic [2:0] CFG_RULE_IPRT = 3'd5;
	localparam logic [2:0] CFG_IDLE_TO   = 3'd6;

	localparam logic [1:0] EW_NONE = 2'd0;
	localparam logic [1:0] EW_HIT  = 2'd1;
	localparam logic [1:0] EW_NEW  = 2'd2;

	localparam logic [1:0] PO_NONE = 2'd0;
	localparam logic [1:0] PO_CLR  = 2'd1;
	localparam logic [1:0] PO_SET  = 2'd2;
	localparam logic [1:0] PO_REL  = 2'd3;

	localparam logic [1:0] RS_NONE = 2'd0;
	localparam logic [1:0] RS_HIT  = 2'd1;
	localparam logic [1:0] RS_NEW  = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [1:0]  direction;
		logic        is_tcp;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic [7:0]  tcp_flags;
		logic [31:0] seq_end;
		logic [31:0] ack_num;
	} pkt_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] out_src_ip;
		logic [15:0] out_src_port;
		logic [31:0] out_dst_ip;
		logic [15:0] out_dst_port;
	} res_item_t;

	typedef struct packed {
		logic [31:0] rem_ip;
		logic [15:0] rem_port;
		logic [31:0] in_ip;
		logic [15:0] in_port;
		logic [31:0] ext_ip;
		logic [15:0] ext_port;
		logic [31:0] last_seen;
		logic [1:0]  fin;
		logic [31:0] in_seq;
		logic [31:0] out_seq;
		logic [31:0] in_ack;
		logic [31:0] out_ack;
	} ent_t;

	typedef struct packed {
		logic               pkt_load;
		logic               tick_inc;
		logic               tbl_rd;
		logic [TBL_IW-1:0]  tbl_addr;
		logic [1:0]         ent_wr;
		logic [TBL_IW-1:0]  wr_addr;
		logic               valid_clr;
		logic               pool_rd;
		logic               pool_src_ent;
		logic [POOL_AW-1:0] pool_addr;
		logic [1:0]         pool_op;
		logic               res_load;
		logic [1:0]         res_act;
		logic [1:0]         res_src;
		logic               out_load;
	} ctl_t;

	typedef struct packed {
		logic               in_tick;
		logic               dir_bad;
		logic               not_tcp;
		logic               inbound;
		logic               syn;
		logic               rule_hit;
		logic               ent_val;
		logic [TBL_IW-1:0]  tag;
		logic               hit;
		logic               tag_free;
		logic               kill;
		logic               kill_pool;
		logic               pool_val;
		logic [POOL_AW-1:0] pool_tag;
		logic               pool_found;
		logic               out_free;
	} dp_st_t;

endpackage

>>> rtl/core/tnt_dpath.sv
// ---------------------------------------------------------------------------
// tnt_dpath
// packet register, mapping table, port pool, config and result registers
// ---------------------------------------------------------------------------
module tnt_dpath import tnt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pkt_item_t   pkt,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  ctl_t        cmd,
	output dp_st_t      st,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res
);

	logic [31:0] ext_ip_q, rule_xip_q, rule_iip_q;
	logic        rule_en_q;
	logic [15:0] rule_xprt_q, rule_iprt_q, idle_to_q;
	logic [31:0] now_q;

	pkt_item_t pkt_q;
	ent_t      ent_mem [TBL_ENTRIES];
	ent_t      ent_s1;
	logic [TBL_IW-1:0] ent_tag_s1;
	logic      ent_val_s1;
	logic [TBL_ENTRIES-1:0] valid_q;

	logic [31:0] pool_mem [POOL_WORDS];
	logic [31:0] pool_s1;
	logic [POOL_AW-1:0] pool_tag_s1;
	logic        pool_val_s1;
	logic [4:0]  rel_bit_q;
	logic [15:0] port_q;

	res_item_t hold_q;
	logic      res_valid_q;
	res_item_t res_q;

	logic        inbound, fin, has_ack;
	logic [31:0] raddr;
	logic [15:0] rport;
	logic        tag_vld, expired, finished, ent_in_pool;
	logic [15:0] ent_off;
	logic [31:0] pool_mask, free_bits;
	logic [4:0]  fbit;
	logic [POOL_AW-1:0] pool_ra;
	ent_t        ent_wd;
	res_item_t   res_d;

	assign inbound = (pkt_q.direction == DIR_IN);
	assign fin     = pkt_q.tcp_flags[FLAG_FIN];
	assign has_ack = pkt_q.tcp_flags[FLAG_ACK];
	assign raddr   = inbound ? pkt_q.src_ip : pkt_q.dst_ip;
	assign rport   = inbound ? pkt_q.src_port : pkt_q.dst_port;
	assign tag_vld = valid_q[ent_tag_s1];

	assign expired  = (now_q - ent_s1.last_seen) > {16'd0, idle_to_q};
	assign finished = (ent_s1.fin == 2'b11) && (ent_s1.in_ack >= ent_s1.out_seq) &&
		(ent_s1.out_ack >= ent_s1.in_seq);
	assign ent_in_pool = (ent_s1.ext_port >= 16'(PORT_FIRST)) &&
		(ent_s1.ext_port <= 16'(PORT_LAST));
	assign ent_off = ent_s1.ext_port - 16'(PORT_FIRST);

	assign pool_mask = (pool_tag_s1 == POOL_AW'(POOL_WORDS - 1)) ? POOL_LAST_MASK : '1;
	assign free_bits = ~pool_s1 & pool_mask;

	always_comb begin
		fbit = '0;
		for (int b = 31; b >= 0; b--) begin
			if (free_bits[b]) fbit = 5'(b);
		end
	end

	assign pool_ra = cmd.pool_src_ent ? ent_off[POOL_OFF_W-1:5] : cmd.pool_addr;

	always_comb begin
		st.in_tick   = pkt.operation;
		st.dir_bad   = pkt_q.direction[1];
		st.not_tcp   = !pkt_q.is_tcp;
		st.inbound   = inbound;
		st.syn       = pkt_q.tcp_flags[FLAG_SYN];
		st.rule_hit  = rule_en_q && (pkt_q.dst_ip == rule_xip_q) &&
			(pkt_q.dst_port == rule_xprt_q);
		st.ent_val   = ent_val_s1;
		st.tag       = ent_tag_s1;
		st.hit       = tag_vld && (ent_s1.rem_ip == raddr) && (ent_s1.rem_port == rport) &&
			(inbound ? (ent_s1.ext_ip == pkt_q.dst_ip && ent_s1.ext_port == pkt_q.dst_port)
			         : (ent_s1.in_ip == pkt_q.src_ip && ent_s1.in_port == pkt_q.src_port));
		st.tag_free  = !tag_vld;
		st.kill      = tag_vld && (expired || finished);
		st.kill_pool = ent_in_pool;
		st.pool_val  = pool_val_s1;
		st.pool_tag  = pool_tag_s1;
		st.pool_found = |free_bits;
		st.out_free  = !res_valid_q || !res_stall;
	end

	// entry write data
	always_comb begin
		ent_wd = ent_s1;
		if (cmd.ent_wr == EW_HIT) begin
			if (inbound) begin
				ent_wd.fin[1]  = fin;
				ent_wd.out_seq = pkt_q.seq_end;
				if (has_ack) ent_wd.out_ack = pkt_q.ack_num;
			end else begin
				ent_wd.fin[0] = fin;
				ent_wd.in_seq = pkt_q.seq_end;
				if (has_ack) ent_wd.in_ack = pkt_q.ack_num;
			end
		end else begin
			ent_wd.rem_ip   = raddr;
			ent_wd.rem_port = rport;
			if (inbound) begin
				ent_wd.in_ip    = rule_iip_q;
				ent_wd.in_port  = rule_iprt_q;
				ent_wd.ext_ip   = rule_xip_q;
				ent_wd.ext_port = rule_xprt_q;
				ent_wd.fin      = {fin, 1'b0};
				ent_wd.out_seq  = pkt_q.seq_end;
				ent_wd.out_ack  = has_ack ? pkt_q.ack_num : 32'd0;
				ent_wd.in_seq   = '0;
				ent_wd.in_ack   = '0;
			end else begin
				ent_wd.in_ip    = pkt_q.src_ip;
				ent_wd.in_port  = pkt_q.src_port;
				ent_wd.ext_ip   = ext_ip_q;
				ent_wd.ext_port = port_q;
				ent_wd.fin      = {1'b0, fin};
				ent_wd.in_seq   = pkt_q.seq_end;
				ent_wd.in_ack   = has_ack ? pkt_q.ack_num : 32'd0;
				ent_wd.out_seq  = '0;
				ent_wd.out_ack  = '0;
			end
		end
		ent_wd.last_seen = now_q;
	end

	// result staging data
	always_comb begin
		res_d = '0;
		res_d.action = cmd.res_act;
		unique case (cmd.res_src)
			RS_HIT: begin
				if (inbound) begin
					res_d.out_src_ip   = pkt_q.src_ip;
					res_d.out_src_port = pkt_q.src_port;
					res_d.out_dst_ip   = ent_s1.in_ip;
					res_d.out_dst_port = ent_s1.in_port;
				end else begin
					res_d.out_src_ip   = ent_s1.ext_ip;
					res_d.out_src_port = ent_s1.ext_port;
					res_d.out_dst_ip   = pkt_q.dst_ip;
					res_d.out_dst_port = pkt_q.dst_port;
				end
			end
			RS_NEW: begin
				if (inbound) begin
					res_d.out_src_ip   = pkt_q.src_ip;
					res_d.out_src_port = pkt_q.src_port;
					res_d.out_dst_ip   = rule_iip_q;
					res_d.out_dst_port = rule_iprt_q;
				end else begin
					res_d.out_src_ip   = ext_ip_q;
					res_d.out_src_port = port_q;
					res_d.out_dst_ip   = pkt_q.dst_ip;
					res_d.out_dst_port = pkt_q.dst_port;
				end
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.ent_wr != EW_NONE) ent_mem[cmd.wr_addr] <= ent_wd;
		if (cmd.tbl_rd) ent_s1 <= ent_mem[cmd.tbl_addr];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.pool_op)
			PO_CLR:  pool_mem[cmd.pool_addr] <= '0;
			PO_SET:  pool_mem[pool_tag_s1] <= pool_s1 | (32'd1 << fbit);
			PO_REL:  pool_mem[pool_tag_s1] <= pool_s1 & ~(32'd1 << rel_bit_q);
			default: ;
		endcase
		if (cmd.pool_rd) pool_s1 <= pool_mem[pool_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.pkt_load) pkt_q <= pkt;
		if (cmd.tbl_rd) ent_tag_s1 <= cmd.tbl_addr;
		if (cmd.pool_rd) begin
			pool_tag_s1 <= pool_ra;
			rel_bit_q   <= ent_off[4:0];
		end
		if (cmd.pool_op == PO_SET)
			port_q <= 16'(PORT_FIRST) + 16'({pool_tag_s1, fbit});
		if (cmd.res_load) hold_q <= res_d;
		if (cmd.out_load) res_q <= hold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_ip_q    <= '0;
			rule_en_q   <= 1'b0;
			rule_xip_q  <= '0;
			rule_xprt_q <= '0;
			rule_iip_q  <= '0;
			rule_iprt_q <= '0;
			idle_to_q   <= 16'd60;
			now_q       <= '0;
			valid_q     <= '0;
			ent_val_s1  <= 1'b0;
			pool_val_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_EXT_IP:    ext_ip_q    <= cfg_data;
					CFG_RULE_EN:   rule_en_q   <= cfg_data[0];
					CFG_RULE_XIP:  rule_xip_q  <= cfg_data;
					CFG_RULE_XPRT: rule_xprt_q <= cfg_data[15:0];
					CFG_RULE_IIP:  rule_iip_q  <= cfg_data;
					CFG_RULE_IPRT: rule_iprt_q <= cfg_data[15:0];
					CFG_IDLE_TO:   idle_to_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.tick_inc) now_q <= now_q + 32'd1;
			if (cmd.ent_wr == EW_NEW) valid_q[cmd.wr_addr] <= 1'b1;
			if (cmd.valid_clr) valid_q[ent_tag_s1] <= 1'b0;
			ent_val_s1  <= cmd.tbl_rd;
			pool_val_s1 <= cmd.pool_rd;
			res_valid_q <= cmd.out_load || (res_valid_q && res_stall);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/core/tnt_ctrl.sv
// ---------------------------------------------------------------------------
// tnt_ctrl
// sequencer for lookup, port allocation, tick sweep and pool clearing
// ---------------------------------------------------------------------------
`include "tcp_nat_translation_table_core_macros.svh"

module tnt_ctrl import tnt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pkt_valid,
	output logic   pkt_stall,
	input  dp_st_t st,
	output ctl_t   cmd
);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLS    = 4'd2;
	localparam logic [3:0] S_LOOK   = 4'd3;
	localparam logic [3:0] S_POOL   = 4'd4;
	localparam logic [3:0] S_NEW    = 4'd5;
	localparam logic [3:0] S_SW_RD  = 4'd6;
	localparam logic [3:0] S_SW_CHK = 4'd7;
	localparam logic [3:0] S_SW_REL = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	localparam logic [TBL_IW-1:0]  IDX_LAST  = TBL_IW'(TBL_ENTRIES - 1);
	localparam logic [POOL_AW-1:0] WORD_LAST = POOL_AW'(POOL_WORDS - 1);

	logic [3:0]         state_q, state_d;
	logic [TBL_IW-1:0]  idx_q, idx_d, free_q, free_d, slot_q, slot_d;
	logic               free_found_q, free_found_d;
	logic [POOL_AW-1:0] word_q, word_d;
	logic               free_any;
	logic [TBL_IW-1:0]  free_idx;

	assign pkt_stall = (state_q != S_IDLE);
	assign free_any  = free_found_q || (st.ent_val && st.tag_free);
	assign free_idx  = free_found_q ? free_q : st.tag;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		idx_d        = idx_q;
		free_d       = free_q;
		free_found_d = free_found_q;
		slot_d       = slot_q;
		word_d       = word_q;
		unique case (state_q)
			S_CLR: begin
				cmd.pool_op   = PO_CLR;
				cmd.pool_addr = word_q;
				word_d        = word_q + 1'b1;
				if (word_q == WORD_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (pkt_valid) begin
					cmd.pkt_load = 1'b1;
					idx_d        = '0;
					if (st.in_tick) begin
						cmd.tick_inc = 1'b1;
						state_d      = S_SW_RD;
					end else begin
						state_d = S_CLS;
					end
				end
			end
			S_CLS: begin
				free_found_d = 1'b0;
				if (st.dir_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_act  = ACT_ICMP;
					state_d      = S_OUT;
				end else if (st.not_tcp) begin
					cmd.res_load = 1'b1;
					cmd.res_act  = ACT_DROP;
					state_d      = S_OUT;
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (st.ent_val && st.tag_free && !free_found_q) begin
					free_found_d = 1'b1;
					free_d       = st.tag;
				end
				if (st.ent_val && st.hit) begin
					cmd.ent_wr   = EW_HIT;
					cmd.wr_addr  = st.tag;
					cmd.res_load = 1'b1;
					cmd.res_act  = ACT_FWD;
					cmd.res_src  = RS_HIT;
					state_d      = S_OUT;
				end else if (st.ent_val && st.tag == IDX_LAST) begin
					slot_d = free_idx;
					word_d = '0;
					if (!st.syn || (!st.inbound || st.rule_hit) && !free_any) begin
						cmd.res_load = 1'b1;
						cmd.res_act  = ACT_ICMP;
						state_d      = S_OUT;
					end else if (st.inbound && !st.rule_hit) begin
						cmd.res_load = 1'b1;
						cmd.res_act  = ACT_DROP;
						state_d      = S_OUT;
					end else if (st.inbound) begin
						state_d = S_NEW;
					end else begin
						state_d = S_POOL;
					end
				end else begin
					cmd.tbl_rd   = 1'b1;
					cmd.tbl_addr = idx_q;
					idx_d        = idx_q + 1'b1;
				end
			end
			S_POOL: begin
				if (st.pool_val && st.pool_found) begin
					cmd.pool_op = PO_SET;
					state_d     = S_NEW;
				end else if (st.pool_val && st.pool_tag == WORD_LAST) begin
					cmd.res_load = 1'b1;
					cmd.res_act  = ACT_ICMP;
					state_d      = S_OUT;
				end else begin
					cmd.pool_rd   = 1'b1;
					cmd.pool_addr = word_q;
					word_d        = word_q + 1'b1;
				end
			end
			S_NEW: begin
				cmd.ent_wr   = EW_NEW;
				cmd.wr_addr  = slot_q;
				cmd.res_load = 1'b1;
				cmd.res_act  = ACT_FWD;
				cmd.res_src  = RS_NEW;
				state_d      = S_OUT;
			end
			S_SW_RD: begin
				cmd.tbl_rd   = 1'b1;
				cmd.tbl_addr = idx_q;
				state_d      = S_SW_CHK;
			end
			S_SW_CHK: begin
				idx_d   = idx_q + 1'b1;
				state_d = (idx_q == IDX_LAST) ? S_IDLE : S_SW_RD;
				if (st.kill) begin
					cmd.valid_clr = 1'b1;
					if (st.kill_pool) begin
						cmd.pool_rd      = 1'b1;
						cmd.pool_src_ent = 1'b1;
						idx_d            = idx_q;
						state_d          = S_SW_REL;
					end
				end
			end
			S_SW_REL: begin
				cmd.pool_op = PO_REL;
				idx_d       = idx_q + 1'b1;
				state_d     = (idx_q == IDX_LAST) ? S_IDLE : S_SW_RD;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			idx_q        <= '0;
			free_q       <= '0;
			free_found_q <= 1'b0;
			slot_q       <= '0;
			word_q       <= '0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			free_q       <= free_d;
			free_found_q <= free_found_d;
			slot_q       <= slot_d;
			word_q       <= word_d;
		end
	end

	`TNT_ASSERT_IMP(a_hit_gives_result, cmd.ent_wr == EW_HIT, cmd.res_load && st.hit, "hit write without result")
	`TNT_ASSERT_IMP(a_set_needs_free, cmd.pool_op == PO_SET, st.pool_val && st.pool_found, "pool set without free port")
	`TNT_ASSERT_NXT(a_new_then_out, state_q == S_NEW, state_q == S_OUT, "new entry not followed by delivery")
	`TNT_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLR, !cmd.pkt_load && pkt_stall, "item taken during pool clear")

endmodule

>>> rtl/core/tcp_nat_translation_table_core.sv
// ---------------------------------------------------------------------------
// tcp_nat_translation_table_core
// tcp port translation table with one destination nat rule
// ---------------------------------------------------------------------------
//  channel  handshake             beat
//  pkt      pkt_valid/pkt_stall   pkt_item_t, packet or one-second tick
//  res      res_valid/res_stall   res_item_t, one per packet, none per tick
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  packet: classified, then a walk of the 64-entry table through its read port
//  new flow: an entry write; outbound first scans up to 348 pool words of 32 ports
//  tick: each table entry is read and checked; a killed entry in the pool releases its port
//  after reset the pool is cleared word by word with pkt stalled
//  a finished result waits in the output register while the next beat is taken
// ---------------------------------------------------------------------------
module tcp_nat_translation_table_core import tnt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_stall,
	input  pkt_item_t   pkt,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ctl_t   cmd;
	dp_st_t st;

	assign cfg_ready = 1'b1;

	tnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tnt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the tcp nat translation table core: a local
// table model predicts each result, random flows, hits, fins and ticks
// ---------------------------------------------------------------------------
module tb_top;
	import tnt_pkg::*;

	class res_scoreboard;
		res_item_t pending[$];
		int errors;
		int matched;

		function void note(res_item_t e);
			pending.push_back(e);
		endfunction

		function void field_cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
			end
		endfunction

		function void check(res_item_t a);
			res_item_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat, actual %h", $time, a);
				return;
			end
			e = pending.pop_front();
			field_cmp("action", 32'(e.action), 32'(a.action));
			field_cmp("out_src_ip", e.out_src_ip, a.out_src_ip);
			field_cmp("out_src_port", 32'(e.out_src_port), 32'(a.out_src_port));
			field_cmp("out_dst_ip", e.out_dst_ip, a.out_dst_ip);
			field_cmp("out_dst_port", 32'(e.out_dst_port), 32'(a.out_dst_port));
			matched++;
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 500;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        pkt_valid = 0;
	logic        pkt_stall;
	pkt_item_t   pkt = '0;
	logic        res_valid;
	logic        res_stall = 0;
	res_item_t   res;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tcp_nat_translation_table_core uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	res_scoreboard sb = new();
	int src_idle = 11;
	int dst_idle = 61;
	bit long_hold = 0;
	int hold_left = 0;
	int cycles = 0;
	int n_pkts = 0;
	int n_ticks = 0;

	// model of the translation table
	logic [31:0] ext_ip_r, rx_ip_r, ri_ip_r;
	logic [15:0] rx_port_r, ri_port_r, idle_r;
	logic        rule_en_r;
	bit          live [TBL_ENTRIES];
	ent_t        flow [TBL_ENTRIES];
	bit          port_used [0:65535];
	logic [31:0] now_s;

	function automatic void advance_clock();
		logic [31:0] age;
		bit done;
		now_s++;
		for (int i = 0; i < TBL_ENTRIES; i++) begin
			if (!live[i]) continue;
			age = now_s - flow[i].last_seen;
			done = flow[i].fin == 2'b11 && flow[i].in_ack >= flow[i].out_seq
				&& flow[i].out_ack >= flow[i].in_seq;
			if (age > {16'd0, idle_r} || done) begin
				if (flow[i].ext_port >= PORT_FIRST && flow[i].ext_port <= PORT_LAST)
					port_used[flow[i].ext_port] = 0;
				live[i] = 0;
			end
		end
	endfunction

	function automatic bit translate(input pkt_item_t p, output res_item_t r);
		bit inb, fin, has_ack;
		logic [31:0] raddr;
		logic [15:0] rport;
		int slot;
		int port;
		r = '0;
		if (p.operation) begin
			advance_clock();
			return 0;
		end
		if (p.direction != DIR_OUT && p.direction != DIR_IN) begin
			r.action = ACT_ICMP;
			return 1;
		end
		if (!p.is_tcp) begin
			r.action = ACT_DROP;
			return 1;
		end
		inb = p.direction == DIR_IN;
		fin = p.tcp_flags[FLAG_FIN];
		has_ack = p.tcp_flags[FLAG_ACK];
		raddr = inb ? p.src_ip : p.dst_ip;
		rport = inb ? p.src_port : p.dst_port;
		r.out_src_ip = p.src_ip;
		r.out_src_port = p.src_port;
		r.out_dst_ip = p.dst_ip;
		r.out_dst_port = p.dst_port;
		for (int i = 0; i < TBL_ENTRIES; i++) begin
			if (!live[i] || flow[i].rem_ip != raddr || flow[i].rem_port != rport) continue;
			if (inb) begin
				if (flow[i].ext_ip != p.dst_ip || flow[i].ext_port != p.dst_port) continue;
				r.out_dst_ip = flow[i].in_ip;
				r.out_dst_port = flow[i].in_port;
				flow[i].fin[1] = fin;
				flow[i].out_seq = p.seq_end;
				if (has_ack) flow[i].out_ack = p.ack_num;
			end else begin
				if (flow[i].in_ip != p.src_ip || flow[i].in_port != p.src_port) continue;
				r.out_src_ip = flow[i].ext_ip;
				r.out_src_port = flow[i].ext_port;
				flow[i].fin[0] = fin;
				flow[i].in_seq = p.seq_end;
				if (has_ack) flow[i].in_ack = p.ack_num;
			end
			flow[i].last_seen = now_s;
			return 1;
		end
		r = '0;
		if (!p.tcp_flags[FLAG_SYN]) begin
			r.action = ACT_ICMP;
			return 1;
		end
		if (inb && !(rule_en_r && p.dst_ip == rx_ip_r && p.dst_port == rx_port_r)) begin
			r.action = ACT_DROP;
			return 1;
		end
		slot = -1;
		for (int i = TBL_ENTRIES - 1; i >= 0; i--)
			if (!live[i]) slot = i;
		if (slot < 0) begin
			r.action = ACT_ICMP;
			return 1;
		end
		if (!inb) begin
			port = 0;
			for (int q = PORT_LAST; q >= PORT_FIRST; q--)
				if (!port_used[q]) port = q;
			if (port == 0) begin
				r.action = ACT_ICMP;
				return 1;
			end
			port_used[port] = 1;
			flow[slot].in_ip = p.src_ip;
			flow[slot].in_port = p.src_port;
			flow[slot].ext_ip = ext_ip_r;
			flow[slot].ext_port = 16'(port);
			flow[slot].fin = {1'b0, fin};
			flow[slot].in_seq = p.seq_end;
			flow[slot].in_ack = has_ack ? p.ack_num : '0;
			flow[slot].out_seq = '0;
			flow[slot].out_ack = '0;
			r.out_src_ip = ext_ip_r;
			r.out_src_port = 16'(port);
			r.out_dst_ip = p.dst_ip;
			r.out_dst_port = p.dst_port;
		end else begin
			flow[slot].in_ip = ri_ip_r;
			flow[slot].in_port = ri_port_r;
			flow[slot].ext_ip = rx_ip_r;
			flow[slot].ext_port = rx_port_r;
			flow[slot].fin = {fin, 1'b0};
			flow[slot].out_seq = p.seq_end;
			flow[slot].out_ack = has_ack ? p.ack_num : '0;
			flow[slot].in_seq = '0;
			flow[slot].in_ack = '0;
			r.out_src_ip = p.src_ip;
			r.out_src_port = p.src_port;
			r.out_dst_ip = ri_ip_r;
			r.out_dst_port = ri_port_r;
		end
		live[slot] = 1;
		flow[slot].rem_ip = raddr;
		flow[slot].rem_port = rport;
		flow[slot].last_seen = now_s;
		return 1;
	endfunction

	// receiver side
	always @(negedge clk) begin
		if (long_hold) begin
			hold_left = 3000;
			long_hold = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall = 1;
		end else begin
			res_stall = $urandom_range(99) < dst_idle;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (res_valid && !res_stall) sb.check(res);
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t cycle limit reached", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_EXT_IP:    ext_ip_r = val;
			CFG_RULE_EN:   rule_en_r = val[0];
			CFG_RULE_XIP:  rx_ip_r = val;
			CFG_RULE_XPRT: rx_port_r = val[15:0];
			CFG_RULE_IIP:  ri_ip_r = val;
			CFG_RULE_IPRT: ri_port_r = val[15:0];
			CFG_IDLE_TO:   idle_r = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send(input pkt_item_t it);
		res_item_t r;
		while ($urandom_range(99) < src_idle) begin
			pkt_valid = 0;
			@(negedge clk);
		end
		pkt = it;
		pkt_valid = 1;
		do @(posedge clk); while (pkt_stall);
		if (translate(it, r)) sb.note(r);
		if (it.operation) n_ticks++;
		else n_pkts++;
		@(negedge clk);
	endtask

	task automatic settle();
		pkt_valid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic pkt_item_t base_pkt(logic [1:0] dir, logic [7:0] flags);
		pkt_item_t p;
		p = '0;
		p.direction = dir;
		p.is_tcp = 1;
		p.tcp_flags = flags;
		p.src_ip = 32'h0a000000 | $urandom_range(3);
		p.src_port = 16'(1000 + $urandom_range(7));
		p.dst_ip = 32'h08080800 | $urandom_range(3);
		case ($urandom_range(3))
			0: p.dst_port = 16'd80;
			1: p.dst_port = 16'd443;
			2: p.dst_port = 16'd0;
			default: p.dst_port = 16'hffff;
		endcase
		p.seq_end = $urandom_range(3);
		p.ack_num = $urandom_range(3);
		return p;
	endfunction

	function automatic logic [7:0] rand_flags();
		logic [7:0] f;
		f = 8'($urandom_range(255)) & ~8'h13;
		f[FLAG_FIN] = $urandom_range(9) < 3;
		f[FLAG_ACK] = $urandom_range(9) < 6;
		f[FLAG_SYN] = $urandom_range(9) < 2;
		return f;
	endfunction

	// packet that follows a live flow in one direction or the other
	function automatic pkt_item_t flow_pkt(int j, bit inb);
		pkt_item_t p;
		p = base_pkt(inb ? DIR_IN : DIR_OUT, rand_flags());
		if (inb) begin
			p.src_ip = flow[j].rem_ip;
			p.src_port = flow[j].rem_port;
			p.dst_ip = flow[j].ext_ip;
			p.dst_port = flow[j].ext_port;
		end else begin
			p.src_ip = flow[j].in_ip;
			p.src_port = flow[j].in_port;
			p.dst_ip = flow[j].rem_ip;
			p.dst_port = flow[j].rem_port;
		end
		if ($urandom_range(9) == 0) begin
			p.seq_end = $urandom;
			p.ack_num = $urandom;
		end
		return p;
	endfunction

	function automatic pkt_item_t rand_pkt();
		pkt_item_t p;
		int k, j, tries;
		logic [191:0] rbits;
		k = $urandom_range(99);
		if (k < 8) begin
			p = '0;
			p.operation = 1;
		end else if (k < 11) begin
			p = base_pkt(2'($urandom_range(2, 3)), rand_flags());
		end else if (k < 14) begin
			p = base_pkt(2'($urandom_range(1)), rand_flags());
			p.is_tcp = 0;
		end else if (k < 34) begin
			p = base_pkt(DIR_OUT, rand_flags() | 8'h02);
		end else if (k < 44) begin
			p = base_pkt(DIR_IN, rand_flags() | 8'h02);
			if ($urandom_range(3) != 0) begin
				p.dst_ip = rx_ip_r;
				p.dst_port = rx_port_r;
			end
		end else if (k < 89) begin
			j = -1;
			for (tries = 0; tries < 8 && j < 0; tries++) begin
				j = $urandom_range(TBL_ENTRIES - 1);
				if (!live[j]) j = -1;
			end
			if (j < 0) p = base_pkt(DIR_OUT, rand_flags() | 8'h02);
			else p = flow_pkt(j, $urandom_range(1));
		end else begin
			rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			p = rbits[$bits(pkt_item_t)-1:0];
			p.operation = 0;
		end
		return p;
	endfunction

	task automatic random_items(int n);
		repeat (n) send(rand_pkt());
	endtask

	task automatic directed();
		pkt_item_t p;
		p = base_pkt(2'd2, 8'h02);
		send(p);
		p.direction = 2'd3;
		send(p);
		p = base_pkt(DIR_OUT, 8'h02);
		p.is_tcp = 0;
		send(p);
		p = base_pkt(DIR_OUT, 8'h10);
		send(p);
		p = base_pkt(DIR_OUT, 8'h02);
		send(p);
		send(flow_pkt(0, 1));
		send(flow_pkt(0, 0));
		p = flow_pkt(0, 1);
		p.tcp_flags = 8'h11;
		p.seq_end = 32'd5;
		p.ack_num = 32'd9;
		send(p);
		p = flow_pkt(0, 0);
		p.tcp_flags = 8'h11;
		p.seq_end = 32'd9;
		p.ack_num = 32'd5;
		send(p);
		p = base_pkt(DIR_IN, 8'h12);
		p.dst_ip = rx_ip_r;
		p.dst_port = rx_port_r;
		send(p);
		send(flow_pkt(1, 0));
		p.dst_port = rx_port_r + 16'd1;
		send(p);
		p = '0;
		p.operation = 1;
		send(p);
		send(p);
		p = '0;
		send(p);
		p = '1;
		p.operation = 0;
		send(p);
		p.direction = DIR_IN;
		send(p);
		p.direction = DIR_OUT;
		send(p);
		p = '0;
		p.is_tcp = 1;
		p.tcp_flags = 8'h02;
		send(p);
	endtask

	initial begin
		ext_ip_r = '0;
		rule_en_r = 0;
		rx_ip_r = '0;
		rx_port_r = '0;
		ri_ip_r = '0;
		ri_port_r = '0;
		idle_r = 16'd60;
		now_s = '0;
		foreach (live[i]) live[i] = 0;
		foreach (port_used[i]) port_used[i] = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		write_reg(CFG_EXT_IP, 32'hc6336401);
		write_reg(CFG_RULE_EN, 32'd1);
		write_reg(CFG_RULE_XIP, 32'hc6336402);
		write_reg(CFG_RULE_XPRT, 32'd8080);
		write_reg(CFG_RULE_IIP, 32'h0a0000c8);
		write_reg(CFG_RULE_IPRT, 32'd80);
		write_reg(CFG_IDLE_TO, 32'd60);
		write_reg(3'd7, 32'hffffffff);
		directed();
		random_items(250);
		settle();

		src_idle = 61;
		dst_idle = 11;
		write_reg(CFG_EXT_IP, 32'hffffffff);
		write_reg(CFG_RULE_XIP, 32'hffffffff);
		write_reg(CFG_RULE_XPRT, 32'hffff);
		write_reg(CFG_RULE_IIP, 32'h0);
		write_reg(CFG_RULE_IPRT, 32'h0);
		write_reg(CFG_IDLE_TO, 32'd3);
		random_items(50);
		src_idle = 0;
		long_hold = 1;
		random_items(40);
		src_idle = 61;
		random_items(160);
		settle();

		src_idle = 0;
		dst_idle = 0;
		write_reg(CFG_EXT_IP, 32'h0);
		write_reg(CFG_RULE_EN, 32'd0);
		write_reg(CFG_IDLE_TO, 32'hffff);
		random_items(125);
		settle();

		write_reg(CFG_RULE_EN, 32'd1);
		write_reg(CFG_RULE_XIP, 32'h0);
		write_reg(CFG_RULE_XPRT, 32'h0);
		write_reg(CFG_IDLE_TO, 32'd0);
		random_items(125);
		settle();

		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0t %0d expected results never arrived", $time, sb.pending.size());
		end
		$display("covered %0d packets and %0d ticks over four register settings", n_pkts,
			n_ticks);
		$display("%0d results matched, %0d errors", sb.matched, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> tcp_nat_translation_table_core.f
+incdir+rtl/core
rtl/core/tnt_pkg.sv
rtl/core/tnt_dpath.sv
rtl/core/tnt_ctrl.sv
rtl/core/tcp_nat_translation_table_core.sv
tb/tb_top.sv
